// File: src/dwt_analysis_filter_bank_unit_assert.svh
// Assertion macros for the wavelet analysis filter bank.
// Used by the top level only; it must provide clk_i and rst_ni.
`ifndef DWT_ANALYSIS_FILTER_BANK_UNIT_ASSERT_SVH
`define DWT_ANALYSIS_FILTER_BANK_UNIT_ASSERT_SVH

// same-cycle implication
`define DWT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dwt_pkg.sv
// Shared constants, types and register codes of the wavelet analysis filter bank.
// No dependencies.
package dwt_pkg;

  localparam int TAP_BITS        = 16;
  localparam int FRAC_BITS       = 14;
  localparam int OUT_BITS        = 20;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int TAP_CNT_W       = 4;
  localparam int NUM_COEF        = 8;
  localparam int TAPS_PER_REG    = 4;
  localparam int DEF_MAX_TAPS    = 8;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LO_FIRST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LO_SECOND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HI_FIRST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HI_SECOND  = 3'd4;

  localparam logic [TAP_CNT_W-1:0]  RST_TAP_COUNT = 4'd2;
  localparam logic [CFG_DATA_W-1:0] RST_LO_FIRST  = 64'd759246145;
  localparam logic [CFG_DATA_W-1:0] RST_LO_SECOND = 64'd0;
  localparam logic [CFG_DATA_W-1:0] RST_HI_FIRST  = 64'd759288511;
  localparam logic [CFG_DATA_W-1:0] RST_HI_SECOND = 64'd0;

  typedef logic signed [TAP_BITS-1:0] coef_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctl_t;

endpackage

// File: src/dwt_window.sv
// Sample delay line with fill count and phase; decides whether a pair is due.
// Depends on dwt_pkg.
module dwt_window #(
  parameter int MAX_TAPS    = dwt_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = dwt_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic                                last_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic [$clog2(MAX_TAPS+1)-1:0]       taps_i,
  input  logic [$clog2(MAX_TAPS)-1:0]         rd_addr_i,
  output logic signed [SAMPLE_BITS-1:0]       rd_data_o,
  output logic                                pair_o
);
  import dwt_pkg::*;

  localparam int TC_W = $clog2(MAX_TAPS+1);

  logic signed [SAMPLE_BITS-1:0] win_q [MAX_TAPS];
  logic [TC_W-1:0] fill_q, fill_d, fill_inc;
  logic            phase_q, phase_d, phase_inc;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      win_q[0] <= sample_i;
      for (int j = 1; j < MAX_TAPS; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  assign rd_data_o = win_q[rd_addr_i];

  always_comb begin
    fill_inc  = (fill_q == TC_W'(MAX_TAPS)) ? fill_q : fill_q + TC_W'(1);
    phase_inc = ~phase_q;
    pair_o    = (fill_inc >= taps_i) && (phase_inc == taps_i[0]);
    fill_d    = fill_q;
    phase_d   = phase_q;
    if (push_i) begin
      fill_d  = last_i ? '0 : fill_inc;
      phase_d = last_i ? 1'b0 : phase_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      phase_q <= phase_d;
    end
  end

endmodule

// File: src/dwt_mac.sv
// Shared multiply-accumulate pair for the low-pass and high-pass sums,
// with round-half-up and 20-bit saturation. Depends on dwt_pkg.
module dwt_mac #(
  parameter int SAMPLE_BITS = dwt_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dwt_pkg::mac_ctl_t                    ctl_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  dwt_pkg::coef_t                       coef_lo_i,
  input  dwt_pkg::coef_t                       coef_hi_i,
  output logic signed [dwt_pkg::OUT_BITS-1:0]  approx_o,
  output logic signed [dwt_pkg::OUT_BITS-1:0]  detail_o
);
  import dwt_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + TAP_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(1 << (FRAC_BITS-1));
  localparam logic signed [ACC_W:0] SAT_HI   = (ACC_W+1)'((1 << (OUT_BITS-1)) - 1);
  localparam logic signed [ACC_W:0] SAT_LO   = -SAT_HI - (ACC_W+1)'(1);

  logic signed [PROD_W-1:0] prod_lo_q, prod_hi_q;
  logic signed [ACC_W-1:0]  acc_lo_q, acc_hi_q;
  logic                     prod_v_q;

  function automatic logic signed [OUT_BITS-1:0] rnd_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] t;
    logic signed [ACC_W:0] q;
    t = $signed({a[ACC_W-1], a}) + RND_HALF;
    q = t >>> FRAC_BITS;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return OUT_BITS'(q);
  endfunction

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_lo_q <= PROD_W'(sample_i) * PROD_W'(coef_lo_i);
      prod_hi_q <= PROD_W'(sample_i) * PROD_W'(coef_hi_i);
    end
    if (ctl_i.clear) begin
      acc_lo_q <= '0;
      acc_hi_q <= '0;
    end else if (prod_v_q) begin
      acc_lo_q <= acc_lo_q + ACC_W'(prod_lo_q);
      acc_hi_q <= acc_hi_q + ACC_W'(prod_hi_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctl_i.mul_en & ~ctl_i.clear;
    end
  end

  assign approx_o = rnd_sat(acc_lo_q);
  assign detail_o = rnd_sat(acc_hi_q);

endmodule

// File: src/dwt_analysis_filter_bank_unit.sv
// Single-level wavelet analysis stage: one sample per beat in, at most one
// approx/detail result per sample out. A sample that completes an even-aligned
// window of T taps keeps the block busy for accept, the shared multiplier pair's
// walk over the taps, accumulate flush, round and load (held while out_stall_i
// keeps a full output register); a last sample without a pair only for the load.
// The result sits in an output register, so the next sample is taken while it
// waits. Depends on dwt_pkg, dwt_window, dwt_mac and the assertion header.
module dwt_analysis_filter_bank_unit #(
  parameter int MAX_TAPS    = dwt_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = dwt_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  logic                                  last_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [dwt_pkg::OUT_BITS-1:0]   approx_o,
  output logic signed [dwt_pkg::OUT_BITS-1:0]   detail_o,
  output logic                                  pair_valid_o,
  output logic                                  end_of_signal_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dwt_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [dwt_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import dwt_pkg::*;

  `include "dwt_analysis_filter_bank_unit_assert.svh"

  localparam int TC_W  = $clog2(MAX_TAPS+1);
  localparam int IDX_W = $clog2(MAX_TAPS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [TAP_CNT_W-1:0]  tc_q;
  logic [CFG_DATA_W-1:0] lo_first_q, lo_second_q, hi_first_q, hi_second_q;
  coef_t                 lo_coef [NUM_COEF];
  coef_t                 hi_coef [NUM_COEF];

  logic [TC_W-1:0]  taps_cl, taps_q, rd_full;
  logic [IDX_W-1:0] k_q, k_d, rd_addr;
  logic             pair_q, pair_d, last_q, last_d;
  logic             in_acc, pair_now, out_load;
  logic signed [SAMPLE_BITS-1:0] win_s;
  logic signed [OUT_BITS-1:0]    mac_approx, mac_detail;
  mac_ctl_t                      mac_ctl;

  logic                       out_valid_q;
  logic signed [OUT_BITS-1:0] approx_q, detail_q;
  logic                       pair_out_q, eos_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q        <= RST_TAP_COUNT;
      lo_first_q  <= RST_LO_FIRST;
      lo_second_q <= RST_LO_SECOND;
      hi_first_q  <= RST_HI_FIRST;
      hi_second_q <= RST_HI_SECOND;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TAP_COUNT: tc_q        <= cfg_data_i[TAP_CNT_W-1:0];
        REG_LO_FIRST:  lo_first_q  <= cfg_data_i;
        REG_LO_SECOND: lo_second_q <= cfg_data_i;
        REG_HI_FIRST:  hi_first_q  <= cfg_data_i;
        REG_HI_SECOND: hi_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < TAPS_PER_REG; i++) begin
      lo_coef[i]                = lo_first_q[i*TAP_BITS +: TAP_BITS];
      lo_coef[i+TAPS_PER_REG]   = lo_second_q[i*TAP_BITS +: TAP_BITS];
      hi_coef[i]                = hi_first_q[i*TAP_BITS +: TAP_BITS];
      hi_coef[i+TAPS_PER_REG]   = hi_second_q[i*TAP_BITS +: TAP_BITS];
    end
  end

  always_comb begin
    if (tc_q == '0) begin
      taps_cl = TC_W'(1);
    end else if (tc_q > TAP_CNT_W'(MAX_TAPS)) begin
      taps_cl = TC_W'(MAX_TAPS);
    end else begin
      taps_cl = TC_W'(tc_q);
    end
  end

  // sequencer
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign rd_full = taps_q - TC_W'(k_q) - TC_W'(1);
  assign rd_addr = rd_full[IDX_W-1:0];

  assign mac_ctl.clear  = in_acc;
  assign mac_ctl.mul_en = (state_q == ST_MAC);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    pair_d  = pair_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pair_d = pair_now;
          last_d = last_sample_i;
          k_d    = '0;
          if (pair_now) begin
            state_d = ST_MAC;
          end else if (last_sample_i) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MAC: begin
        if (TC_W'(k_q) == taps_q - TC_W'(1)) begin
          state_d = ST_FLUSH;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_FLUSH: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      pair_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      pair_q  <= pair_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      taps_q <= taps_cl;
    end
  end

  dwt_window #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_acc),
    .last_i    (last_sample_i),
    .sample_i  (sample_i),
    .taps_i    (taps_cl),
    .rd_addr_i (rd_addr),
    .rd_data_o (win_s),
    .pair_o    (pair_now)
  );

  dwt_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .sample_i  (win_s),
    .coef_lo_i (lo_coef[3'(k_q)]),
    .coef_hi_i (hi_coef[3'(k_q)]),
    .approx_o  (mac_approx),
    .detail_o  (mac_detail)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      approx_q   <= pair_q ? mac_approx : '0;
      detail_q   <= pair_q ? mac_detail : '0;
      pair_out_q <= pair_q;
      eos_q      <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign approx_o        = approx_q;
  assign detail_o        = detail_q;
  assign pair_valid_o    = pair_out_q;
  assign end_of_signal_o = eos_q;

  `DWT_ASSERT_NOW(a_mac_in_range, state_q == ST_MAC, (TC_W'(k_q) < taps_q) && pair_q,
                  "tap walk past tap count")
  `DWT_ASSERT_NOW(a_empty_is_eos, out_valid_o && !pair_valid_o, end_of_signal_o,
                  "empty result without end of signal")
  `DWT_ASSERT_NEXT(a_last_gives_result, in_acc && last_sample_i,
                   state_q == ST_MAC || state_q == ST_DONE,
                   "last sample did not start a result")
  `DWT_ASSERT_NEXT(a_quiet_sample, in_acc && !pair_now && !last_sample_i,
                   state_q == ST_IDLE, "sample without pair left idle")

endmodule
